@@ src/indexed_shift_list_macros.svh @@
// ----------------------------------------------------------------------------
// Indexed shift list assertion macros
// Shared assertion forms used by the list's RTL. They rely on clk and rst_n
// being present in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_LIST_MACROS_SVH
`define INDEXED_SHIFT_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/isl_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed shift list package
// Word types, operation and status codes, and the command that passes from
// the classifying front end to the list engine.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int QUEUE_DEPTH  = 2;
  localparam int OP_W         = 3;
  localparam int IDX_W        = 7;
  localparam int DATA_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 7;
  localparam int CMD_ADDR_W   = 12;

  localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
  localparam logic [OP_W-1:0] OP_GET     = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
  localparam logic [OP_W-1:0] OP_REPLACE = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_WRITE,
    ACT_READ,
    ACT_SHIFT_UP,
    ACT_SHIFT_DOWN
  } act_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_word;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
  } out_word_t;

  typedef struct packed {
    act_t                     act;
    logic [CMD_ADDR_W-1:0]    addr;
    logic                     has_move;
    logic [CMD_ADDR_W-1:0]    first;
    logic [CMD_ADDR_W-1:0]    last;
    logic signed [DATA_W-1:0] value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
  } cmd_t;

endpackage

@@ src/isl_ram.sv @@
// ----------------------------------------------------------------------------
// Indexed shift list RAM
// Simple dual-port memory: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module isl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ src/isl_queue.sv @@
// ----------------------------------------------------------------------------
// Indexed shift list queue
// Small first-in first-out buffer that decouples two sides of the list.
// ----------------------------------------------------------------------------
module isl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = isl_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]    level_r, level_nxt;
  logic             do_push, do_pop;

  assign full     = (level_r == LW'(DEPTH));
  assign empty    = (level_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + LW'(1);
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/isl_front.sv @@
// ----------------------------------------------------------------------------
// Indexed shift list front end
// Accepts requests, keeps the authoritative entry count and turns each
// request into a fully resolved command for the list engine.
// ----------------------------------------------------------------------------
module isl_front #(
  parameter int CAPACITY = isl_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  isl_pkg::in_word_t in_word,
  input  logic              cmd_full,
  output logic              cmd_push,
  output isl_pkg::cmd_t     cmd
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int W  = (CW > isl_pkg::IDX_W) ? CW : isl_pkg::IDX_W;
  localparam int AW = isl_pkg::CMD_ADDR_W;

  logic [CW-1:0] count_r, count_nxt;
  logic [W-1:0]  idx_x, cnt_x, cap_x, cnt_new;
  logic          accept;

  assign accept   = in_push & ~cmd_full;
  assign cmd_push = accept;

  always_comb begin
    idx_x        = W'(in_word.index);
    cnt_x        = W'(count_r);
    cap_x        = W'(CAPACITY);
    cnt_new      = cnt_x;
    cmd.act      = isl_pkg::ACT_NONE;
    cmd.addr     = AW'(idx_x);
    cmd.has_move = 1'b0;
    cmd.first    = '0;
    cmd.last     = '0;
    cmd.value    = in_word.value;
    cmd.status   = isl_pkg::ST_OK;
    case (in_word.operation)
      isl_pkg::OP_APPEND: begin
        if (cnt_x == cap_x) begin
          cmd.status = isl_pkg::ST_FULL;
        end else begin
          cmd.act  = isl_pkg::ACT_WRITE;
          cmd.addr = AW'(cnt_x);
          cnt_new  = cnt_x + W'(1);
        end
      end
      isl_pkg::OP_INSERT: begin
        if (idx_x > cnt_x) begin
          cmd.status = isl_pkg::ST_RANGE;
        end else if (cnt_x == cap_x) begin
          cmd.status = isl_pkg::ST_FULL;
        end else begin
          cmd.act      = isl_pkg::ACT_SHIFT_UP;
          cmd.has_move = (cnt_x > idx_x);
          cmd.first    = AW'(cnt_x - W'(1));
          cmd.last     = AW'(idx_x);
          cnt_new      = cnt_x + W'(1);
        end
      end
      isl_pkg::OP_GET: begin
        if (idx_x >= cnt_x) begin
          cmd.status = isl_pkg::ST_RANGE;
        end else begin
          cmd.act = isl_pkg::ACT_READ;
        end
      end
      isl_pkg::OP_REMOVE: begin
        if (idx_x >= cnt_x) begin
          cmd.status = isl_pkg::ST_RANGE;
        end else begin
          cmd.act      = isl_pkg::ACT_SHIFT_DOWN;
          cmd.has_move = ((idx_x + W'(1)) < cnt_x);
          cmd.first    = AW'(idx_x + W'(1));
          cmd.last     = AW'(cnt_x - W'(1));
          cnt_new      = cnt_x - W'(1);
        end
      end
      isl_pkg::OP_REPLACE: begin
        if (idx_x >= cnt_x) begin
          cmd.status = isl_pkg::ST_RANGE;
        end else begin
          cmd.act = isl_pkg::ACT_WRITE;
        end
      end
      isl_pkg::OP_CLEAR: begin
        cnt_new = '0;
      end
      default: begin
        cnt_new = cnt_x;
      end
    endcase
    cmd.count = isl_pkg::COUNT_W'(cnt_new);
    count_nxt = accept ? CW'(cnt_new) : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ src/isl_back.sv @@
// ----------------------------------------------------------------------------
// Indexed shift list engine
// Carries out resolved commands on the entry memory, moving one word per
// cycle for inserts and removals, and produces one result word per command.
// ----------------------------------------------------------------------------
`include "indexed_shift_list_macros.svh"

module isl_back #(
  parameter int CAPACITY = isl_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  isl_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output isl_pkg::out_word_t res
);

  localparam int AW = $clog2(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_GET_WAIT = 4'b0010,
    S_MOVE     = 4'b0100,
    S_INS_WR   = 4'b1000
  } back_state_t;

  back_state_t   state_r, state_nxt;
  isl_pkg::cmd_t cur_r, cur_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [isl_pkg::DATA_W-1:0]    ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [isl_pkg::DATA_W-1:0]    ram_rdata;
  logic                          going_up;

  isl_ram #(
    .WIDTH(isl_pkg::DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr  (ram_raddr),
    .rdata_r(ram_rdata)
  );

  assign going_up = (cur_r.act == isl_pkg::ACT_SHIFT_UP);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    ptr_nxt       = ptr_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res.read_word = '0;
    res.status    = cur_r.status;
    res.count     = cur_r.count;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = ptr_r;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop    = 1'b1;
          cur_nxt    = cmd;
          res.status = cmd.status;
          res.count  = cmd.count;
          case (cmd.act)
            isl_pkg::ACT_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = AW'(cmd.addr);
              ram_wdata = cmd.value;
              res_push  = 1'b1;
            end
            isl_pkg::ACT_READ: begin
              ram_raddr = AW'(cmd.addr);
              state_nxt = S_GET_WAIT;
            end
            isl_pkg::ACT_SHIFT_UP, isl_pkg::ACT_SHIFT_DOWN: begin
              if (cmd.has_move) begin
                ram_raddr = AW'(cmd.first);
                ptr_nxt   = AW'(cmd.first);
                state_nxt = S_MOVE;
              end else if (cmd.act == isl_pkg::ACT_SHIFT_UP) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cmd.addr);
                ram_wdata = cmd.value;
                res_push  = 1'b1;
              end else begin
                res_push = 1'b1;
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      S_GET_WAIT: begin
        res.read_word = ram_rdata;
        res_push      = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = going_up ? ptr_r + AW'(1) : ptr_r - AW'(1);
        if (ptr_r == AW'(cur_r.last)) begin
          if (going_up) begin
            state_nxt = S_INS_WR;
          end else begin
            res_push  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          ptr_nxt   = going_up ? ptr_r - AW'(1) : ptr_r + AW'(1);
          ram_raddr = ptr_nxt;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cur_r.addr);
        ram_wdata = cur_r.value;
        res_push  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    ptr_r <= ptr_nxt;
  end

  `ISL_ASSERT_SAME(a_pop_only_idle, cmd_pop, state_r == S_IDLE, "command taken while busy")
  `ISL_ASSERT_SAME(a_slot_reserved, state_r != S_IDLE, !res_full, "no result slot held")
  `ISL_ASSERT_NEXT(a_get_result, cmd_pop && cmd.act == isl_pkg::ACT_READ, state_r == S_GET_WAIT && res_push, "get result missing")
  `ISL_ASSERT_SAME(a_write_in_range, ram_we, {1'b0, ram_waddr} < (AW + 1)'(CAPACITY), "write beyond capacity")

endmodule

@@ src/indexed_shift_list.sv @@
// ----------------------------------------------------------------------------
// Indexed shift list
// A fixed-capacity ordered list of signed 32-bit words with append, insert,
// get, remove, replace and clear, one result word per request word.
// ----------------------------------------------------------------------------
// Requests are classified on entry, so status and count are known at once;
// the engine then works through them one at a time from a two-word queue,
// with a two-word result queue behind it. Append, replace, clear, unused
// codes and every failed request finish in the idle state; a get reads the
// memory, then returns the word from a wait state; an insert that moves
// entries shifts them up, then writes the new word; one at the end writes
// at once; a removal shifts later entries down unless it is of the last.
// The single entry memory moves one word per cycle through its one read
// and one write port. The memory needs no clearing after reset.
module indexed_shift_list #(
  parameter int CAPACITY = isl_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  isl_pkg::in_word_t  in_word,
  output logic               out_empty,
  input  logic               out_pop,
  output isl_pkg::out_word_t out_word
);

  localparam int CMD_W = $bits(isl_pkg::cmd_t);
  localparam int RES_W = $bits(isl_pkg::out_word_t);

  logic               cmd_full, cmd_push, cmd_empty, cmd_pop;
  isl_pkg::cmd_t      cmd_in, cmd_out;
  logic               res_full, res_push;
  isl_pkg::out_word_t res_in;

  assign in_full = cmd_full;

  isl_front #(
    .CAPACITY(CAPACITY)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_word (in_word),
    .cmd_full(cmd_full),
    .cmd_push(cmd_push),
    .cmd     (cmd_in)
  );

  isl_queue #(
    .WIDTH(CMD_W),
    .DEPTH(isl_pkg::QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd_in),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .pop_data (cmd_out),
    .empty    (cmd_empty)
  );

  isl_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(cmd_empty),
    .cmd      (cmd_out),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  isl_queue #(
    .WIDTH(RES_W),
    .DEPTH(isl_pkg::QUEUE_DEPTH)
  ) u_res_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_in),
    .full     (res_full),
    .pop      (out_pop),
    .pop_data (out_word),
    .empty    (out_empty)
  );

endmodule
